>>> src/sbp_pkg.sv
package sbp_pkg;

    // Widths of the register port and of the data path
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned APB_ADDR_W  = 4;
    localparam int unsigned SYM_W       = 8;
    localparam int unsigned WIDTH_W     = 4;
    localparam int unsigned PEND_W      = 7;
    localparam int unsigned COUNT_W     = 3;
    localparam int unsigned ACC_W       = PEND_W + SYM_W;

    // Register indexes (byte address divided by four)
    localparam logic [1:0] REG_SYM_WIDTH   = 2'd0;
    localparam logic [1:0] REG_MSB_FIRST   = 2'd1;
    localparam logic [1:0] REG_REVERSE_OUT = 2'd2;

    // Reset value of the width register, and the largest symbol width
    localparam logic [WIDTH_W-1:0] SYM_WIDTH_RST    = 4'd1;
    localparam logic [WIDTH_W-1:0] MAX_SYMBOL_WIDTH = 4'd8;

    // Configuration as seen by the packing stage
    typedef struct packed {
        logic [WIDTH_W-1:0] sym_width;
        logic               msb_first;
        logic               reverse_out;
    } sbp_cfg_t;

    // Bit-order mirror of one byte
    function automatic logic [SYM_W-1:0] mirror8(input logic [SYM_W-1:0] value);
        logic [SYM_W-1:0] result;
        result = '0;
        for (int k = 0; k < SYM_W; k++)
        begin
            result[SYM_W-1-k] = value[k];
        end
        return result;
    endfunction

endpackage

>>> src/sbp_apb_regs.sv
module sbp_apb_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sbp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sbp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sbp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output sbp_pkg::sbp_cfg_t                cfg
);
    import sbp_pkg::*;

    logic [WIDTH_W-1:0] sym_width_reg;
    logic               msb_first_reg;
    logic               reverse_out_reg;
    logic [1:0]         reg_index;
    logic               write_en;

    // The port never inserts wait states.
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign write_en  = psel && penable && pwrite && pready;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_width_reg   <= SYM_WIDTH_RST;
            msb_first_reg   <= 1'b0;
            reverse_out_reg <= 1'b0;
        end
        else if (write_en)
        begin
            unique case (reg_index)
                REG_SYM_WIDTH:   sym_width_reg   <= pwdata[WIDTH_W-1:0];
                REG_MSB_FIRST:   msb_first_reg   <= pwdata[0];
                REG_REVERSE_OUT: reverse_out_reg <= pwdata[0];
                default:         ;
            endcase
        end
    end

    // Read-back of the register values.
    always_comb
    begin
        prdata = '0;
        unique case (reg_index)
            REG_SYM_WIDTH:   prdata = {{(APB_DATA_W-WIDTH_W){1'b0}}, sym_width_reg};
            REG_MSB_FIRST:   prdata = {{(APB_DATA_W-1){1'b0}}, msb_first_reg};
            REG_REVERSE_OUT: prdata = {{(APB_DATA_W-1){1'b0}}, reverse_out_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.sym_width   = sym_width_reg;
    assign cfg.msb_first   = msb_first_reg;
    assign cfg.reverse_out = reverse_out_reg;

endmodule

>>> src/sbp_pack_stage.sv
module sbp_pack_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sbp_pkg::sbp_cfg_t           cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [sbp_pkg::SYM_W-1:0]   symbol_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sbp_pkg::SYM_W-1:0]   packed_byte
);
    import sbp_pkg::*;

    // Input register
    logic               in_valid_reg;
    logic [SYM_W-1:0]   in_byte_reg;

    // Stream state
    logic [PEND_W-1:0]  pending_bits_reg;
    logic [PEND_W-1:0]  pending_bits_next;
    logic [COUNT_W-1:0] pending_count_reg;
    logic [COUNT_W-1:0] pending_count_next;

    // Result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [SYM_W-1:0]   out_byte_reg;
    logic [SYM_W-1:0]   out_byte_next;

    // Packing logic
    logic               consume;
    logic [WIDTH_W-1:0] width_eff;
    logic [SYM_W-1:0]   width_mask;
    logic [SYM_W-1:0]   seq;
    logic [ACC_W-1:0]   acc;
    logic [WIDTH_W-1:0] total;
    logic               byte_done;
    logic [SYM_W-1:0]   raw_byte;

    // The held item moves on whenever the result register is free or being emptied.
    assign consume  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= symbol_byte;
        end
    end

    // Symbol width, with widths above eight acting as eight.
    assign width_eff  = (cfg.sym_width > MAX_SYMBOL_WIDTH) ? MAX_SYMBOL_WIDTH
                                                           : cfg.sym_width;
    assign width_mask = SYM_W'((9'd1 << width_eff) - 9'd1);

    // Symbol bits in stream order, first stream bit in bit 0.
    always_comb
    begin
        if (cfg.msb_first)
        begin
            seq = mirror8(in_byte_reg) >> (MAX_SYMBOL_WIDTH - width_eff);
        end
        else
        begin
            seq = in_byte_reg & width_mask;
        end
    end

    // Merge the symbol behind the pending bits.
    assign acc       = {{SYM_W{1'b0}}, pending_bits_reg}
                     | ({{PEND_W{1'b0}}, seq} << pending_count_reg);
    assign total     = {1'b0, pending_count_reg} + width_eff;
    assign byte_done = total >= MAX_SYMBOL_WIDTH;
    assign raw_byte  = acc[SYM_W-1:0];

    // Next stream state and result.
    always_comb
    begin
        pending_bits_next  = pending_bits_reg;
        pending_count_next = pending_count_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        out_byte_next      = out_byte_reg;
        if (consume)
        begin
            if (byte_done)
            begin
                pending_bits_next  = acc[ACC_W-1:SYM_W];
                pending_count_next = total[COUNT_W-1:0];
                out_valid_next     = 1'b1;
                out_byte_next      = cfg.reverse_out ? mirror8(raw_byte) : raw_byte;
            end
            else
            begin
                pending_bits_next  = acc[PEND_W-1:0];
                pending_count_next = total[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_bits_reg  <= '0;
            pending_count_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            pending_bits_reg  <= pending_bits_next;
            pending_count_reg <= pending_count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
    end

    assign out_valid   = out_valid_reg;
    assign packed_byte = out_byte_reg;

    // A completed byte always reaches the result register.
    a_byte_lands: assert property (@(posedge clk) disable iff (!rst_n)
        consume && byte_done |=> out_valid_reg)
        else $error("completed byte did not reach the result register");

    // A held item waits unchanged while the result register is blocked.
    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !consume |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held item lost while the result register was blocked");

    // The stream state moves only when an item is consumed.
    a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !consume |=> $stable(pending_count_reg) && $stable(pending_bits_reg))
        else $error("stream state changed without a consumed item");

    // A zero-width symbol leaves the stream state untouched.
    a_zero_width: assert property (@(posedge clk) disable iff (!rst_n)
        consume && (width_eff == '0) |=> $stable(pending_count_reg)
                                         && $stable(pending_bits_reg))
        else $error("zero-width symbol changed the stream state");

endmodule

>>> src/symbol_bit_packer.sv
// symbol_bit_packer: packs variable-width symbols into a byte stream.
//
// Input channel (in_valid / in_ready / symbol_byte): one transaction per
// symbol; the low sym_width bits of symbol_byte are appended to the
// stream, LSB first or, with msb_first set, from the symbol's top bit down.
// Output channel (out_valid / out_ready / packed_byte): one transaction for
// every eight stream bits gathered; reverse_out places the first stream bit
// at bit 7 instead of bit 0. Bits still pending at the end are not emitted.
// Registers are written through the APB port at byte addresses 0, 4 and 8.
//
// One symbol is accepted every cycle while the receiver keeps up. A packed
// byte passes through the input register and then the result register:
// the symbol that completes it sits in the input register while the
// shift-and-merge logic feeds the result register.
// When the receiver stalls, the result register holds its byte and one more
// symbol waits in the input register; after that in_ready falls.
// Reset clears the pending bits and both register stages, and loads the
// register reset values (one bit per symbol, LSB first, no reversal).
module symbol_bit_packer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [sbp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sbp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sbp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [sbp_pkg::SYM_W-1:0]        symbol_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [sbp_pkg::SYM_W-1:0]        packed_byte
);
    import sbp_pkg::*;

    sbp_cfg_t cfg;

    // Configuration registers
    sbp_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Packing stage
    sbp_pack_stage u_pack (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .symbol_byte (symbol_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .packed_byte (packed_byte)
    );

endmodule

>>> dv/symbol_bit_packer_tb.sv
`timescale 1ns / 100ps

module symbol_bit_packer_tb;

    import sbp_pkg::*;

    // Register index with nothing behind it; writes to it must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Idling schedules: sender seldom idle and receiver busy, the reverse, then none.
    localparam int MODE_SEND_SPARSE = 0;
    localparam int MODE_RECV_SPARSE = 1;
    localparam int MODE_NO_IDLE     = 2;

    localparam int PHASES           = 24;
    localparam int ITEMS_PER_PHASE  = 80;
    localparam int HOLD_OFF_CYCLES  = 80;
    localparam int SETTLE_CYCLES    = 6;
    localparam int STALL_LIMIT      = 2000;

    // Scoreboard: tracks the packing state and the packed bytes still owed.
    class packed_byte_scoreboard;
        logic [WIDTH_W-1:0] sym_width;
        logic               msb_first;
        logic               reverse_out;
        logic [PEND_W-1:0]  pending_bits;
        int unsigned        pending_count;
        logic [SYM_W-1:0]   expected_bytes[$];
        int                 errors;

        function new();
            sym_width     = SYM_WIDTH_RST;
            msb_first     = 1'b0;
            reverse_out   = 1'b0;
            pending_bits  = '0;
            pending_count = 0;
            errors        = 0;
        endfunction

        task report_error(input string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        // Mirror a register write; unknown indexes leave everything alone.
        function void apply_write(input logic [1:0] idx, input logic [31:0] value);
            case (idx)
                REG_SYM_WIDTH:   sym_width = value[WIDTH_W-1:0];
                REG_MSB_FIRST:   msb_first = value[0];
                REG_REVERSE_OUT: reverse_out = value[0];
                default: ;
            endcase
        endfunction

        // Append one symbol to the stream and queue a packed byte if one completes.
        function void note_symbol(input logic [SYM_W-1:0] sym);
            int unsigned      width;
            int unsigned      total;
            logic [SYM_W-1:0] ordered;
            logic [ACC_W-1:0] merged;
            logic [SYM_W-1:0] out_bits;
            logic [SYM_W-1:0] flipped;
            width   = (sym_width > MAX_SYMBOL_WIDTH) ? SYM_W : sym_width;
            ordered = '0;
            // Stream order: the first bit to go out sits in bit 0.
            for (int j = 0; j < width; j++)
                ordered[j] = msb_first ? sym[width-1-j] : sym[j];
            merged = ACC_W'(pending_bits) | (ACC_W'(ordered) << pending_count);
            total  = pending_count + width;
            if (total < SYM_W)
            begin
                pending_bits  = merged[PEND_W-1:0];
                pending_count = total;
            end
            else
            begin
                out_bits      = merged[SYM_W-1:0];
                pending_bits  = merged[ACC_W-1:SYM_W];
                pending_count = total - SYM_W;
                for (int k = 0; k < SYM_W; k++)
                    flipped[SYM_W-1-k] = out_bits[k];
                expected_bytes.push_back(reverse_out ? flipped : out_bits);
            end
        endfunction

        task check_packed(input logic [SYM_W-1:0] got);
            logic [SYM_W-1:0] want;
            if (expected_bytes.size() == 0)
                report_error($sformatf("packed_byte 0x%02h with nothing expected", got));
            else
            begin
                want = expected_bytes.pop_front();
                if (got !== want)
                    report_error($sformatf("packed_byte 0x%02h, expected 0x%02h", got, want));
            end
        endtask

        function int outstanding();
            return expected_bytes.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [SYM_W-1:0]        symbol_byte = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [SYM_W-1:0]        packed_byte;

    packed_byte_scoreboard sb = new();
    int idle_mode = MODE_NO_IDLE;
    int hold_cycles = 0;
    int stall_count = 0;

    symbol_bit_packer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .symbol_byte (symbol_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .packed_byte (packed_byte)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Observe both channels; a stretch with no transaction at all ends the run.
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            sb.note_symbol(symbol_byte);
        if (out_valid && out_ready)
            sb.check_packed(packed_byte);
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_count = 0;
        else
            stall_count++;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: a requested hold-off takes priority over the random back-pressure.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else if (idle_mode == MODE_SEND_SPARSE)
                out_ready <= ($urandom_range(0, 99) >= 56);
            else if (idle_mode == MODE_RECV_SPARSE)
                out_ready <= ($urandom_range(0, 99) >= 7);
            else
                out_ready <= 1'b1;
        end
    end

    // Offer one symbol and hold it until the transaction completes.
    task automatic send_symbol(input logic [SYM_W-1:0] value);
        int gap_pct;
        gap_pct = (idle_mode == MODE_SEND_SPARSE) ? 7 :
                  (idle_mode == MODE_RECV_SPARSE) ? 56 : 0;
        in_valid    <= 1'b1;
        symbol_byte <= value;
        do @(posedge clk); while (!in_ready);
        // Each following cycle idles with the schedule's probability.
        if ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
        end
    endtask

    // Let every owed byte drain, then give the pipeline time to settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // The bus returns to idle between writes.
        @(posedge clk);
        sb.apply_write(idx, value);
    endtask

    // Rewrite all registers once the block is quiet; upper data bits are noise.
    task automatic configure(input logic [3:0] width, input logic msb, input logic rev);
        wait_idle();
        write_reg(REG_SYM_WIDTH, ($urandom & ~32'hF) | width);
        write_reg(REG_MSB_FIRST, ($urandom & ~32'h1) | msb);
        write_reg(REG_REVERSE_OUT, ($urandom & ~32'h1) | rev);
        write_reg(REG_UNUSED, $urandom);
    endtask

    initial
    begin
        logic [3:0] width;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one bit per symbol, so only bit 0 of each byte counts.
        send_symbol(8'h01); send_symbol(8'hFE); send_symbol(8'hFF); send_symbol(8'h00);
        send_symbol(8'h80); send_symbol(8'h7F); send_symbol(8'h55); send_symbol(8'hAA);

        // Full-width symbols taken from the top bit, with the output mirrored.
        configure(4'd8, 1'b1, 1'b1);
        send_symbol(8'hFF); send_symbol(8'h00); send_symbol(8'h81);

        // Zero width appends nothing, whatever the input byte holds.
        configure(4'd0, 1'b0, 1'b0);
        send_symbol(8'hFF); send_symbol(8'hA5);

        // Widths above eight behave as eight.
        configure(4'd15, 1'b0, 1'b0);
        send_symbol(8'h00); send_symbol(8'hFF); send_symbol(8'h3C);

        // A write to the unused index must not disturb the three-bit setting.
        configure(4'd3, 1'b1, 1'b0);
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        send_symbol(8'h07); send_symbol(8'hF8); send_symbol(8'h05); send_symbol(8'hFA);

        // Random phases: every width value, both bit orders and both output orders.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase < 16)
                width = 4'((phase * 5) % 16);
            else if (phase == 16)
                width = 4'd1;
            else if (phase == 17)
                width = 4'd8;
            else
                width = 4'($urandom_range(0, 15));
            configure(width, phase[1], phase[2]);
            idle_mode = (phase < 8) ? MODE_SEND_SPARSE :
                        (phase < 16) ? MODE_RECV_SPARSE : MODE_NO_IDLE;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Long receiver hold-off so the block fills and pushes back.
                if ((phase == 1 || phase == 17) && i == ITEMS_PER_PHASE / 2)
                    hold_cycles = HOLD_OFF_CYCLES;
                send_symbol(8'($urandom_range(0, 255)));
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.report_error($sformatf("%0d packed bytes never arrived", sb.outstanding()));
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
